// ===== rtl/core/vcps_pkg.sv =====
package vcps_pkg;

    localparam int MAX_VERTS  = 256;
    localparam int COORD_BITS = 24;
    localparam int ID_BITS    = 20;

    // offset from the site needs one bit more than a coordinate
    localparam int OFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * OFF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 1;
    localparam int SQ_BITS   = PROD_BITS;
    localparam int SLOT_BITS = $clog2(MAX_VERTS);
    localparam int CNT_BITS  = SLOT_BITS + 1;
    localparam int STEP_BITS = 2;

    localparam logic ACTION_SITE   = 1'b0;
    localparam logic ACTION_VERTEX = 1'b1;

    // mac sequence: x, y, z products, then the final add
    localparam logic [STEP_BITS-1:0] STEP_X   = STEP_BITS'(0);
    localparam logic [STEP_BITS-1:0] STEP_Y   = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] STEP_Z   = STEP_BITS'(2);
    localparam logic [STEP_BITS-1:0] STEP_ADD = STEP_BITS'(3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_STORE,
        S_FIN,
        S_RD,
        S_DOT,
        S_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic add_en;
    } t_mac_ctrl;

    typedef struct packed {
        logic [SQ_BITS-1:0]         sq;
        logic [ID_BITS-1:0]         id;
        logic signed [OFF_BITS-1:0] x;
        logic signed [OFF_BITS-1:0] y;
        logic signed [OFF_BITS-1:0] z;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

// ===== rtl/core/vcps_in_if.sv =====
interface vcps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic signed [vcps_pkg::COORD_BITS-1:0] coord_x;
    logic signed [vcps_pkg::COORD_BITS-1:0] coord_y;
    logic signed [vcps_pkg::COORD_BITS-1:0] coord_z;
    logic [vcps_pkg::ID_BITS-1:0]         vertex_id;
    logic                                 last;

    modport source (
        output valid, action, coord_x, coord_y, coord_z, vertex_id, last,
        input  ready
    );

    modport sink (
        input  valid, action, coord_x, coord_y, coord_z, vertex_id, last,
        output ready
    );
endinterface

// ===== rtl/core/vcps_out_if.sv =====
interface vcps_out_if;
    logic                         valid;
    logic                         ready;
    logic                         first_valid;
    logic [vcps_pkg::ID_BITS-1:0] first_pole;
    logic                         second_valid;
    logic [vcps_pkg::ID_BITS-1:0] second_pole;
    logic                         overflow;

    modport source (
        output valid, first_valid, first_pole, second_valid, second_pole, overflow,
        input  ready
    );

    modport sink (
        input  valid, first_valid, first_pole, second_valid, second_pole, overflow,
        output ready
    );
endinterface

// ===== rtl/core/voronoi_cell_pole_select.sv =====
// Picks the two poles of a Voronoi cell from a site item and the vertex items that follow it.
// One 25x25 multiplier with an accumulator is shared by the squares and the dot products, so a
// stored vertex goes through the offset, three squares, the final add and the store before the
// next item can be taken; site items and dropped vertices need none of these steps. An item
// marked last then starts a second pass over the N stored vertices, with a read, three
// dot-product steps, the final add and a compare for each, before the result is offered (the
// pass is skipped when no first pole was found); the block takes no item until that result
// has been transferred. The vertex store holds 256 entries; vertices beyond that are dropped
// and reported in the overflow field. Ties keep the earlier vertex, and a vertex on the site
// is never chosen.
module voronoi_cell_pole_select (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vcps_in_if.sink           i_in,
    vcps_out_if.source        o_out
);

    vcps_pkg::t_state r_state;
    vcps_pkg::t_state n_state;

    logic signed [vcps_pkg::COORD_BITS-1:0] r_site_x, r_site_y, r_site_z;
    logic signed [vcps_pkg::COORD_BITS-1:0] n_site_x, n_site_y, n_site_z;
    logic [vcps_pkg::CNT_BITS-1:0]          r_count, n_count;
    logic [vcps_pkg::SQ_BITS-1:0]           r_best_sq, n_best_sq;
    logic                                   r_best_found, n_best_found;
    logic                                   r_dropped, n_dropped;
    logic                                   r_second_found, n_second_found;
    logic [vcps_pkg::STEP_BITS-1:0]         r_step, n_step;
    logic [vcps_pkg::CNT_BITS-1:0]          r_idx, n_idx;

    logic signed [vcps_pkg::OFF_BITS-1:0]   r_off_x, r_off_y, r_off_z;
    logic signed [vcps_pkg::OFF_BITS-1:0]   n_off_x, n_off_y, n_off_z;
    logic [vcps_pkg::ID_BITS-1:0]           r_id, n_id;
    logic                                   r_last, n_last;
    logic signed [vcps_pkg::OFF_BITS-1:0]   r_best_x, r_best_y, r_best_z;
    logic signed [vcps_pkg::OFF_BITS-1:0]   n_best_x, n_best_y, n_best_z;
    logic [vcps_pkg::ID_BITS-1:0]           r_best_id, n_best_id;
    logic [vcps_pkg::SQ_BITS-1:0]           r_best2_sq, n_best2_sq;
    logic [vcps_pkg::ID_BITS-1:0]           r_second_id, n_second_id;

    vcps_pkg::t_mac_ctrl                    mac_ctrl;
    logic signed [vcps_pkg::OFF_BITS-1:0]   mac_a, mac_b;
    logic signed [vcps_pkg::ACC_BITS-1:0]   mac_acc;
    logic [vcps_pkg::SQ_BITS-1:0]           mac_sq;

    logic                                   ram_we, ram_re;
    logic [vcps_pkg::SLOT_BITS-1:0]         ram_waddr, ram_raddr;
    vcps_pkg::t_entry                       wr_entry, rd_entry;
    logic [vcps_pkg::ENTRY_BITS-1:0]        ram_rdata;

    vcps_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_acc  (mac_acc)
    );

    vcps_ram #(
        .WIDTH (vcps_pkg::ENTRY_BITS),
        .DEPTH (vcps_pkg::MAX_VERTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = ram_rdata;
    assign mac_sq   = mac_acc[vcps_pkg::SQ_BITS-1:0];

    assign ram_waddr = r_count[vcps_pkg::SLOT_BITS-1:0];
    assign ram_raddr = r_idx[vcps_pkg::SLOT_BITS-1:0];

    always_comb begin
        wr_entry.sq = mac_sq;
        wr_entry.id = r_id;
        wr_entry.x  = r_off_x;
        wr_entry.y  = r_off_y;
        wr_entry.z  = r_off_z;
    end

    // operand select: squares of the new offset while loading, dot against first pole in pass
    always_comb begin
        mac_a = r_off_x;
        mac_b = r_off_x;
        if (r_state == vcps_pkg::S_DOT) begin
            case (r_step)
                vcps_pkg::STEP_X: begin
                    mac_a = r_best_x;
                    mac_b = rd_entry.x;
                end
                vcps_pkg::STEP_Y: begin
                    mac_a = r_best_y;
                    mac_b = rd_entry.y;
                end
                default: begin
                    mac_a = r_best_z;
                    mac_b = rd_entry.z;
                end
            endcase
        end else begin
            case (r_step)
                vcps_pkg::STEP_X: begin
                    mac_a = r_off_x;
                    mac_b = r_off_x;
                end
                vcps_pkg::STEP_Y: begin
                    mac_a = r_off_y;
                    mac_b = r_off_y;
                end
                default: begin
                    mac_a = r_off_z;
                    mac_b = r_off_z;
                end
            endcase
        end
    end

    assign i_in.ready = (r_state == vcps_pkg::S_IDLE);

    assign o_out.valid        = (r_state == vcps_pkg::S_OUT);
    assign o_out.first_valid  = r_best_found;
    assign o_out.first_pole   = r_best_found ? r_best_id : '0;
    assign o_out.second_valid = r_second_found;
    assign o_out.second_pole  = r_second_found ? r_second_id : '0;
    assign o_out.overflow     = r_dropped;

    always_comb begin
        n_state        = r_state;
        n_site_x       = r_site_x;
        n_site_y       = r_site_y;
        n_site_z       = r_site_z;
        n_count        = r_count;
        n_best_sq      = r_best_sq;
        n_best_found   = r_best_found;
        n_dropped      = r_dropped;
        n_second_found = r_second_found;
        n_step         = r_step;
        n_idx          = r_idx;
        n_off_x        = r_off_x;
        n_off_y        = r_off_y;
        n_off_z        = r_off_z;
        n_id           = r_id;
        n_last         = r_last;
        n_best_x       = r_best_x;
        n_best_y       = r_best_y;
        n_best_z       = r_best_z;
        n_best_id      = r_best_id;
        n_best2_sq     = r_best2_sq;
        n_second_id    = r_second_id;
        mac_ctrl       = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (r_state)
            vcps_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.action == vcps_pkg::ACTION_SITE) begin
                        n_site_x     = i_in.coord_x;
                        n_site_y     = i_in.coord_y;
                        n_site_z     = i_in.coord_z;
                        n_count      = '0;
                        n_best_sq    = '0;
                        n_best_found = 1'b0;
                        n_dropped    = 1'b0;
                        if (i_in.last) begin
                            n_state = vcps_pkg::S_FIN;
                        end
                    end else if (r_count == vcps_pkg::CNT_BITS'(vcps_pkg::MAX_VERTS)) begin
                        n_dropped = 1'b1;
                        if (i_in.last) begin
                            n_state = vcps_pkg::S_FIN;
                        end
                    end else begin
                        n_off_x = vcps_pkg::OFF_BITS'(i_in.coord_x)
                                - vcps_pkg::OFF_BITS'(r_site_x);
                        n_off_y = vcps_pkg::OFF_BITS'(i_in.coord_y)
                                - vcps_pkg::OFF_BITS'(r_site_y);
                        n_off_z = vcps_pkg::OFF_BITS'(i_in.coord_z)
                                - vcps_pkg::OFF_BITS'(r_site_z);
                        n_id    = i_in.vertex_id;
                        n_last  = i_in.last;
                        n_step  = vcps_pkg::STEP_X;
                        n_state = vcps_pkg::S_SQ;
                    end
                end
            end

            vcps_pkg::S_SQ, vcps_pkg::S_DOT: begin
                mac_ctrl.clr    = (r_step == vcps_pkg::STEP_X);
                mac_ctrl.mul_en = (r_step != vcps_pkg::STEP_ADD);
                mac_ctrl.add_en = (r_step != vcps_pkg::STEP_X);
                n_step          = r_step + 1'b1;
                if (r_step == vcps_pkg::STEP_ADD) begin
                    n_state = (r_state == vcps_pkg::S_SQ) ? vcps_pkg::S_STORE
                                                          : vcps_pkg::S_CMP;
                end
            end

            vcps_pkg::S_STORE: begin
                ram_we  = 1'b1;
                n_count = r_count + 1'b1;
                // strictly farther wins, so ties keep the earlier vertex
                if (mac_sq > r_best_sq) begin
                    n_best_sq    = mac_sq;
                    n_best_found = 1'b1;
                    n_best_x     = r_off_x;
                    n_best_y     = r_off_y;
                    n_best_z     = r_off_z;
                    n_best_id    = r_id;
                end
                n_state = r_last ? vcps_pkg::S_FIN : vcps_pkg::S_IDLE;
            end

            vcps_pkg::S_FIN: begin
                n_second_found = 1'b0;
                n_second_id    = '0;
                n_best2_sq     = '0;
                n_idx          = '0;
                n_state        = r_best_found ? vcps_pkg::S_RD : vcps_pkg::S_OUT;
            end

            vcps_pkg::S_RD: begin
                ram_re  = 1'b1;
                n_step  = vcps_pkg::STEP_X;
                n_state = vcps_pkg::S_DOT;
            end

            vcps_pkg::S_CMP: begin
                // sign bit of the accumulated dot product
                if (mac_acc[vcps_pkg::ACC_BITS-1] && (rd_entry.sq > r_best2_sq)) begin
                    n_best2_sq     = rd_entry.sq;
                    n_second_id    = rd_entry.id;
                    n_second_found = 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = (r_idx + 1'b1 == r_count) ? vcps_pkg::S_OUT : vcps_pkg::S_RD;
            end

            vcps_pkg::S_OUT: begin
                if (o_out.ready) begin
                    n_count      = '0;
                    n_best_sq    = '0;
                    n_best_found = 1'b0;
                    n_dropped    = 1'b0;
                    n_state      = vcps_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = vcps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_x       <= '0;
            r_site_y       <= '0;
            r_site_z       <= '0;
            r_count        <= '0;
            r_best_sq      <= '0;
            r_best_found   <= 1'b0;
            r_dropped      <= 1'b0;
            r_second_found <= 1'b0;
            r_step         <= vcps_pkg::STEP_X;
            r_idx          <= '0;
        end else begin
            r_site_x       <= n_site_x;
            r_site_y       <= n_site_y;
            r_site_z       <= n_site_z;
            r_count        <= n_count;
            r_best_sq      <= n_best_sq;
            r_best_found   <= n_best_found;
            r_dropped      <= n_dropped;
            r_second_found <= n_second_found;
            r_step         <= n_step;
            r_idx          <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off_x     <= n_off_x;
        r_off_y     <= n_off_y;
        r_off_z     <= n_off_z;
        r_id        <= n_id;
        r_last      <= n_last;
        r_best_x    <= n_best_x;
        r_best_y    <= n_best_y;
        r_best_z    <= n_best_z;
        r_best_id   <= n_best_id;
        r_best2_sq  <= n_best2_sq;
        r_second_id <= n_second_id;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= vcps_pkg::CNT_BITS'(vcps_pkg::MAX_VERTS))
        else $error("vertex count beyond store depth");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_found == (r_best_sq != '0))
        else $error("first pole flag disagrees with best distance");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vcps_pkg::S_RD) |-> (r_idx < r_count))
        else $error("pass reads beyond stored vertices");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.second_valid || o_out.first_valid))
        else $error("second pole without first pole");

    a_region_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> (r_count == '0 && !r_best_found && !r_dropped))
        else $error("region not reopened after result transfer");
`endif

endmodule

// ===== rtl/core/vcps_ram.sv =====
module vcps_ram #(
    parameter int  WIDTH     = 8,
    parameter int  DEPTH     = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/vcps_mac.sv =====
module vcps_mac (
    input  logic                                   i_clk,
    input  vcps_pkg::t_mac_ctrl                    i_ctrl,
    input  logic signed [vcps_pkg::OFF_BITS-1:0]   i_a,
    input  logic signed [vcps_pkg::OFF_BITS-1:0]   i_b,
    output logic signed [vcps_pkg::ACC_BITS-1:0]   o_acc
);

    logic signed [vcps_pkg::PROD_BITS-1:0] r_prod;
    logic signed [vcps_pkg::ACC_BITS-1:0]  r_acc;
    logic signed [vcps_pkg::ACC_BITS-1:0]  n_acc;

    // product is registered; the add uses the previous step's product
    always_comb begin
        n_acc = i_ctrl.clr ? '0 : r_acc;
        if (i_ctrl.add_en) begin
            n_acc = n_acc + vcps_pkg::ACC_BITS'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic signed [vcps_pkg::COORD_BITS-1:0] C_MIN =
        {1'b1, {(vcps_pkg::COORD_BITS-1){1'b0}}};
    localparam logic signed [vcps_pkg::COORD_BITS-1:0] C_MAX =
        {1'b0, {(vcps_pkg::COORD_BITS-1){1'b1}}};
    localparam logic [vcps_pkg::ID_BITS-1:0]           ID_MAX = '1;
    localparam int N_ITEMS = 820;

    typedef struct packed {
        logic                                   action;
        logic signed [vcps_pkg::COORD_BITS-1:0] x;
        logic signed [vcps_pkg::COORD_BITS-1:0] y;
        logic signed [vcps_pkg::COORD_BITS-1:0] z;
        logic [vcps_pkg::ID_BITS-1:0]           id;
        logic                                   last;
    } t_vertex_item;

    typedef struct packed {
        logic                         first_valid;
        logic [vcps_pkg::ID_BITS-1:0] first_pole;
        logic                         second_valid;
        logic [vcps_pkg::ID_BITS-1:0] second_pole;
        logic                         overflow;
    } t_pole_result;

    class pole_scoreboard;
        longint                       site_x, site_y, site_z;
        longint                       off_x [vcps_pkg::MAX_VERTS];
        longint                       off_y [vcps_pkg::MAX_VERTS];
        longint                       off_z [vcps_pkg::MAX_VERTS];
        logic [vcps_pkg::ID_BITS-1:0] ids [vcps_pkg::MAX_VERTS];
        int                           count;
        longint                       best_sq;
        int                           best_slot;
        bit                           best_found;
        bit                           dropped;
        t_pole_result                 pending [$];
        int                           failures;

        function new();
            site_x = 0;
            site_y = 0;
            site_z = 0;
            failures = 0;
            open_region();
        endfunction

        function void open_region();
            count = 0;
            best_sq = 0;
            best_slot = 0;
            best_found = 0;
            dropped = 0;
        endfunction

        function longint sq_len(longint x, longint y, longint z);
            return x * x + y * y + z * z;
        endfunction

        function bit dot_negative(int a, int b);
            longint p, q, r;
            p = off_x[a] * off_x[b];
            q = off_y[a] * off_y[b];
            r = off_z[a] * off_z[b];
            return (p + q) < -r;
        endfunction

        // one accepted input transfer; pushes a pole pair when the region closes
        function void note_item(t_vertex_item it);
            longint                       dx, dy, dz, d, best2;
            bit                           found2;
            logic [vcps_pkg::ID_BITS-1:0] id2;
            t_pole_result                 r;
            int                           i;
            if (it.action == vcps_pkg::ACTION_SITE) begin
                site_x = longint'(it.x);
                site_y = longint'(it.y);
                site_z = longint'(it.z);
                open_region();
            end else if (count >= vcps_pkg::MAX_VERTS) begin
                dropped = 1;
            end else begin
                dx = longint'(it.x) - site_x;
                dy = longint'(it.y) - site_y;
                dz = longint'(it.z) - site_z;
                d = sq_len(dx, dy, dz);
                off_x[count] = dx;
                off_y[count] = dy;
                off_z[count] = dz;
                ids[count] = it.id;
                // strictly farther only, so ties keep the earlier vertex
                if (d > best_sq) begin
                    best_sq = d;
                    best_slot = count;
                    best_found = 1;
                end
                count++;
            end
            if (!it.last)
                return;
            best2 = 0;
            found2 = 0;
            id2 = '0;
            if (best_found) begin
                for (i = 0; i < count; i++) begin
                    d = sq_len(off_x[i], off_y[i], off_z[i]);
                    if (dot_negative(best_slot, i) && d > best2) begin
                        best2 = d;
                        id2 = ids[i];
                        found2 = 1;
                    end
                end
            end
            r.first_valid = best_found;
            r.first_pole = best_found ? ids[best_slot] : '0;
            r.second_valid = found2;
            r.second_pole = id2;
            r.overflow = dropped;
            pending.push_back(r);
            open_region();
        endfunction

        function void check_result(t_pole_result got);
            t_pole_result want;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result first %0b/%0h second %0b/%0h ovf %0b",
                             $realtime, got.first_valid, got.first_pole, got.second_valid,
                             got.second_pole, got.overflow);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display({"%0t: mismatch first %0b/%0h second %0b/%0h ovf %0b, ",
                              "expected first %0b/%0h second %0b/%0h ovf %0b"},
                             $realtime, got.first_valid, got.first_pole, got.second_valid,
                             got.second_pole, got.overflow, want.first_valid,
                             want.first_pole, want.second_valid, want.second_pole,
                             want.overflow);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   items_sent;

    pole_scoreboard sb = new();

    vcps_in_if  in_if ();
    vcps_out_if out_if ();

    voronoi_cell_pole_select uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_result(t_pole_result'{out_if.first_valid, out_if.first_pole,
                                           out_if.second_valid, out_if.second_pole,
                                           out_if.overflow});
    end

    task automatic send(input logic action,
                        input logic signed [vcps_pkg::COORD_BITS-1:0] x,
                        input logic signed [vcps_pkg::COORD_BITS-1:0] y,
                        input logic signed [vcps_pkg::COORD_BITS-1:0] z,
                        input logic [vcps_pkg::ID_BITS-1:0] id, input logic last);
        t_vertex_item it;
        it = '{action, x, y, z, id, last};
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.action    <= action;
        in_if.coord_x   <= x;
        in_if.coord_y   <= y;
        in_if.coord_z   <= z;
        in_if.vertex_id <= id;
        in_if.last      <= last;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1)
            @(posedge i_clk);
        sb.note_item(it);
        items_sent++;
    endtask

    // 0: full range, 1: tiny cube around the origin (ties, zero offsets), 2: corners, zero or a random value
    function automatic logic signed [vcps_pkg::COORD_BITS-1:0] rand_coord(int mode);
        case (mode)
            1: return vcps_pkg::COORD_BITS'(int'($urandom_range(6)) - 3);
            2: begin
                case ($urandom_range(3))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return '0;
                    default: return vcps_pkg::COORD_BITS'($urandom);
                endcase
            end
            default: return vcps_pkg::COORD_BITS'($urandom);
        endcase
    endfunction

    initial begin
        int  region_no, n, mode, k, phase, cycles;
        bit  broken;
        in_if.valid     = 1'b0;
        in_if.action    = vcps_pkg::ACTION_SITE;
        in_if.coord_x   = '0;
        in_if.coord_y   = '0;
        in_if.coord_z   = '0;
        in_if.vertex_id = '0;
        in_if.last      = 1'b0;
        i_rst_n         = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        items_sent      = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty region
        send(vcps_pkg::ACTION_SITE, 0, 0, 0, ID_MAX, 1'b1);
        // lone vertex on the site: no poles at all
        send(vcps_pkg::ACTION_SITE, 0, 0, 0, 0, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, 0, 0, 0, 20'h5, 1'b1);
        // site in a corner: first pole only
        send(vcps_pkg::ACTION_SITE, C_MAX, C_MAX, C_MAX, 0, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, C_MIN, C_MIN, C_MIN, ID_MAX, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, C_MAX, C_MAX, C_MAX, 20'h1, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, C_MAX, C_MAX, C_MIN, 20'h2, 1'b1);
        // ties on both poles keep the earlier vertex
        send(vcps_pkg::ACTION_SITE, 0, 0, 0, 0, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, 100, 0, 0, 20'd10, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, 0, 100, 0, 20'd11, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, -50, 0, 0, 20'd12, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, -30, -40, 0, 20'd14, 1'b1);
        // new site abandons the open region
        send(vcps_pkg::ACTION_SITE, 5, 5, 5, 0, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, 9, 9, 9, 20'd20, 1'b0);
        send(vcps_pkg::ACTION_SITE, C_MIN, C_MIN, C_MIN, ID_MAX, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, C_MAX, C_MAX, C_MAX, 20'd21, 1'b1);
        // vertices after last reopen a region around the same site
        send(vcps_pkg::ACTION_VERTEX, C_MIN, C_MAX, 0, 20'd22, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, C_MAX, C_MIN, 7, 20'd23, 1'b1);
        // extreme mixed signs, later vertex strictly farther
        send(vcps_pkg::ACTION_SITE, 0, 0, 0, 0, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, C_MAX, C_MIN, C_MAX, ID_MAX, 1'b0);
        send(vcps_pkg::ACTION_VERTEX, C_MIN, C_MAX, C_MIN, 0, 1'b1);

        region_no = 0;
        while (items_sent < N_ITEMS) begin
            phase = (items_sent / 200) % 4;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            mode = $urandom_range(2);
            if (region_no == 8) begin
                n = vcps_pkg::MAX_VERTS;
                mode = 0;
            end else if (region_no == 20) begin
                // store overflows, extra vertices are dropped
                n = vcps_pkg::MAX_VERTS + $urandom_range(1, 6);
                mode = 0;
            end else if ($urandom_range(99) < 6) begin
                n = 0;
            end else if ($urandom_range(99) < 80) begin
                n = $urandom_range(1, 8);
            end else begin
                n = $urandom_range(9, 40);
            end
            broken = (n > 1) && ($urandom_range(99) < 8);
            if (region_no == 0 || n == 0 || $urandom_range(99) < 90)
                send(vcps_pkg::ACTION_SITE, rand_coord(mode), rand_coord(mode),
                     rand_coord(mode), vcps_pkg::ID_BITS'($urandom), n == 0);
            for (k = 0; k < n; k++)
                send(vcps_pkg::ACTION_VERTEX, rand_coord(mode), rand_coord(mode),
                     rand_coord(mode), vcps_pkg::ID_BITS'($urandom),
                     !broken && (k == n - 1));
            region_no++;
        end
        @(negedge i_clk);
        in_if.valid <= 1'b0;

        cycles = 0;
        while (sb.pending.size() != 0 && cycles < 200000) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (64) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $display("%0d expected results never arrived", sb.pending.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vcps_pkg.sv
rtl/core/vcps_in_if.sv
rtl/core/vcps_out_if.sv
rtl/core/vcps_ram.sv
rtl/core/vcps_mac.sv
rtl/core/voronoi_cell_pole_select.sv
tb/tb.sv
